/* src/gdbo_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package gdbo_pkg;
    typedef enum logic [1:0] {
        ACT_CLEAR    = 2'd0,
        ACT_ADD      = 2'd1,
        ACT_TRAVERSE = 2'd2,
        ACT_NONE     = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_ADD_B,
        ST_DFS_TOP,
        ST_DFS_ROW,
        ST_DFS_SCAN,
        ST_BFS_POP,
        ST_BFS_ROW,
        ST_BFS_SCAN,
        ST_OUT_WAIT
    } state_t;

    localparam int ROW_W = 32;
    localparam int IDX_W = 5;
    localparam int VTX_W = 6;
endpackage
`default_nettype wire

/* src/graph_dfs_bfs_order.sv */
// clear: one adjacency row per cycle; add: read-modify-write of both rows
// traverse: a read of the stack top and its row per stack visit, a push per depth-first
// vertex found, then a read of the queue head and its row per queue entry, an enqueue per
// new neighbor breadth-first; a stalled result holds the walk
// one item at a time: the input is stalled until the current item is done
// reset clears control state, then a pass over every row clears the adjacency rows (input stalled)
`timescale 1ns / 1ps
`default_nettype none
module graph_dfs_bfs_order #(
    parameter int MAX_VERTICES = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] action,
    input  wire logic [5:0] end_a,
    input  wire logic [5:0] end_b,
    input  wire logic [5:0] start_vertex,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [5:0]      vertex,
    output logic            order_kind,
    output logic            last_of_run
);
    import gdbo_pkg::*;

    localparam logic [VTX_W-1:0] NV = VTX_W'(MAX_VERTICES);

    logic [ROW_W-1:0] adj_mem [ROW_W];
    logic [ROW_W-1:0] rd_data;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [ROW_W-1:0] wr_data;

    logic [IDX_W-1:0] stk_v [ROW_W];
    logic [VTX_W-1:0] stk_n [ROW_W];
    logic [IDX_W-1:0] que [ROW_W];
    logic [IDX_W-1:0] stk_rd_v;
    logic [VTX_W-1:0] stk_rd_n;
    logic [IDX_W-1:0] que_rd;

    state_t state_reg, state_next, ret_reg, ret_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] a_reg, a_next, b_reg, b_next;
    logic [ROW_W-1:0] seen_reg, seen_next;
    logic [VTX_W-1:0] top_reg, top_next;
    logic [VTX_W-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [IDX_W-1:0] cur_v_reg, cur_v_next;
    logic [VTX_W-1:0] cur_n_reg, cur_n_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic             ov_reg, ov_next;
    logic [IDX_W-1:0] ovx_reg, ovx_next;
    logic             ok_reg, ok_next, ol_reg, ol_next;

    logic             stk_we, que_we;
    logic [IDX_W-1:0] stk_wa, que_wa;
    logic [IDX_W-1:0] stk_wv, que_wv;
    logic [VTX_W-1:0] stk_wn;
    logic [IDX_W-1:0] stk_ra;
    logic [ROW_W-1:0] cand, cand_lo, fresh, vmask;
    logic [IDX_W-1:0] first_idx;
    logic             found;
    logic             busy_out;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            adj_mem[wr_addr] <= wr_data;
        end
        rd_data <= adj_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_v[stk_wa] <= stk_wv;
            stk_n[stk_wa] <= stk_wn;
        end
        if (que_we)
        begin
            que[que_wa] <= que_wv;
        end
        stk_rd_v <= stk_v[stk_ra];
        stk_rd_n <= stk_n[stk_ra];
        que_rd   <= que[head_reg[IDX_W-1:0]];
    end

    always_comb
    begin
        for (int i = 0; i < ROW_W; i++)
        begin
            vmask[i] = (i < MAX_VERTICES);
        end
    end

    // lowest candidate at or above the current neighbor index
    always_comb
    begin
        cand = row_reg & ~seen_reg & vmask;
        for (int i = 0; i < ROW_W; i++)
        begin
            cand_lo[i] = cand[i] && (VTX_W'(i) >= cur_n_reg);
        end
        found     = |cand_lo;
        first_idx = '0;
        for (int i = ROW_W - 1; i >= 0; i--)
        begin
            if (cand_lo[i])
            begin
                first_idx = IDX_W'(i);
            end
        end
        fresh = cand;
    end

    assign busy_out = ov_reg && out_stall;
    assign stk_ra   = top_reg[IDX_W-1:0] - 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            ret_reg   <= ST_IDLE;
            cnt_reg   <= '0;
            top_reg   <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            cnt_reg   <= cnt_next;
            top_reg   <= top_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        seen_reg  <= seen_next;
        cur_v_reg <= cur_v_next;
        cur_n_reg <= cur_n_next;
        row_reg   <= row_next;
        ovx_reg   <= ovx_next;
        ok_reg    <= ok_next;
        ol_reg    <= ol_next;
    end

    always_comb
    begin
        logic [IDX_W-1:0] t;
        logic [VTX_W-1:0] nt;
        state_next = state_reg;
        ret_next   = ret_reg;
        cnt_next   = cnt_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        seen_next  = seen_reg;
        top_next   = top_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        cur_v_next = cur_v_reg;
        cur_n_next = cur_n_reg;
        row_next   = row_reg;
        ov_next    = ov_reg && out_stall;
        ovx_next   = ovx_reg;
        ok_next    = ok_reg;
        ol_next    = ol_reg;
        rd_addr    = cur_v_reg;
        wr_en      = 1'b0;
        wr_addr    = a_reg;
        wr_data    = '0;
        stk_we     = 1'b0;
        stk_wa     = '0;
        stk_wv     = '0;
        stk_wn     = '0;
        que_we     = 1'b0;
        que_wa     = '0;
        que_wv     = '0;
        in_stall   = 1'b1;
        t          = top_reg[IDX_W-1:0] - 1'b1;
        nt         = VTX_W'(first_idx) + 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = busy_out;
                if (in_valid && !busy_out)
                begin
                    unique case (action_t'(action))
                        ACT_CLEAR:
                        begin
                            cnt_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        ACT_ADD:
                        begin
                            if (end_a >= 6'd1 && end_a <= NV && end_b >= 6'd1 && end_b <= NV)
                            begin
                                a_next     = IDX_W'(end_a - 6'd1);
                                b_next     = IDX_W'(end_b - 6'd1);
                                rd_addr    = IDX_W'(end_a - 6'd1);
                                state_next = ST_ADD_B;
                                cnt_next   = '0;
                            end
                        end
                        ACT_TRAVERSE:
                        begin
                            head_next = '0;
                            tail_next = '0;
                            top_next  = '0;
                            seen_next = '0;
                            if (start_vertex >= 6'd1 && start_vertex <= NV)
                            begin
                                a_next     = IDX_W'(start_vertex - 6'd1);
                                seen_next  = ROW_W'(1) << (start_vertex - 6'd1);
                                stk_we     = 1'b1;
                                stk_wa     = '0;
                                stk_wv     = IDX_W'(start_vertex - 6'd1);
                                stk_wn     = '0;
                                top_next   = 6'd1;
                                ov_next    = 1'b1;
                                ovx_next   = IDX_W'(start_vertex - 6'd1);
                                ok_next    = 1'b0;
                                ol_next    = 1'b0;
                                state_next = ST_DFS_TOP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = cnt_reg;
                wr_data  = '0;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == IDX_W'(ROW_W - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_ADD_B:
            begin
                // two passes: row a then row b, each read then written
                if (cnt_reg == '0)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = a_reg;
                    wr_data  = rd_data | (ROW_W'(1) << b_reg);
                    rd_addr  = b_reg;
                    cnt_next = 5'd1;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = b_reg;
                    wr_data    = (a_reg == b_reg) ? (rd_data | (ROW_W'(1) << b_reg))
                                                  : (rd_data | (ROW_W'(1) << a_reg));
                    state_next = ST_IDLE;
                end
            end
            ST_DFS_TOP:
            begin
                if (top_reg == '0)
                begin
                    seen_next  = ROW_W'(1) << a_reg;
                    que_we     = 1'b1;
                    que_wa     = '0;
                    que_wv     = a_reg;
                    tail_next  = 6'd1;
                    head_next  = '0;
                    state_next = ST_BFS_POP;
                end
                else
                begin
                    state_next = ST_DFS_ROW;
                end
            end
            ST_DFS_ROW:
            begin
                cur_v_next = stk_rd_v;
                cur_n_next = stk_rd_n;
                rd_addr    = stk_rd_v;
                state_next = ST_DFS_SCAN;
                ret_next   = ST_DFS_SCAN;
            end
            ST_DFS_SCAN:
            begin
                if (ret_reg == ST_DFS_SCAN)
                begin
                    row_next = rd_data;
                    ret_next = ST_IDLE;
                end
                else if (!found)
                begin
                    top_next   = top_reg - 1'b1;
                    state_next = ST_DFS_TOP;
                end
                else if (!busy_out)
                begin
                    stk_we     = 1'b1;
                    stk_wa     = t;
                    stk_wv     = cur_v_reg;
                    stk_wn     = nt;
                    state_next = ST_OUT_WAIT;
                    seen_next  = seen_reg | (ROW_W'(1) << first_idx);
                    ov_next    = 1'b1;
                    ovx_next   = first_idx;
                    ok_next    = 1'b0;
                    ol_next    = 1'b0;
                    cur_v_next = first_idx;
                    cur_n_next = '0;
                    if (top_reg < 6'd32)
                    begin
                        top_next = top_reg + 1'b1;
                    end
                end
            end
            ST_OUT_WAIT:
            begin
                // push of the new vertex onto the stack
                stk_we     = 1'b1;
                stk_wa     = t;
                stk_wv     = cur_v_reg;
                stk_wn     = '0;
                state_next = ST_DFS_TOP;
            end
            ST_BFS_POP:
            begin
                if (head_reg >= tail_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    head_next  = head_reg + 1'b1;
                    state_next = ST_BFS_ROW;
                end
            end
            ST_BFS_ROW:
            begin
                cur_v_next = que_rd;
                rd_addr    = que_rd;
                ret_next   = ST_BFS_SCAN;
                state_next = ST_BFS_SCAN;
                cur_n_next = '0;
            end
            ST_BFS_SCAN:
            begin
                if (ret_reg == ST_BFS_SCAN)
                begin
                    row_next = rd_data;
                    ret_next = ST_IDLE;
                end
                else if (found && !fresh[cur_n_reg[IDX_W-1:0]])
                begin
                    cur_n_next = VTX_W'(first_idx);
                end
                else if (found)
                begin
                    seen_next  = seen_reg | (ROW_W'(1) << first_idx);
                    if (tail_reg < 6'd32)
                    begin
                        que_we    = 1'b1;
                        que_wa    = tail_reg[IDX_W-1:0];
                        que_wv    = first_idx;
                        tail_next = tail_reg + 1'b1;
                    end
                    cur_n_next = nt;
                end
                else if (!busy_out)
                begin
                    ov_next    = 1'b1;
                    ovx_next   = cur_v_reg;
                    ok_next    = 1'b1;
                    ol_next    = (head_reg >= tail_reg);
                    state_next = ST_BFS_POP;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid   = ov_reg;
    assign vertex      = VTX_W'(ovx_reg) + 6'd1;
    assign order_kind  = ok_reg;
    assign last_of_run = ol_reg;
endmodule
`default_nettype wire

/* src/gdbo_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module gdbo_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [5:0] vertex,
    input wire logic       order_kind,
    input wire logic       last_of_run
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(vertex))
        else $error("stalled result changed");
    a_last_bfs: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_of_run |-> order_kind)
        else $error("last flag on depth-first result");
    a_vtx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> vertex != 6'd0)
        else $error("vertex zero");
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && order_kind && !last_of_run ##1 out_valid |-> order_kind)
        else $error("depth-first after breadth-first");
endmodule
bind graph_dfs_bfs_order gdbo_checker u_gdbo_checker (.*);
`default_nettype wire
